[rtl/ackermann_dead_reckoning_odometry_defines.svh]
// ----------------------------------------------------------------------------
// ackermann odometry assertion macros
// shared concurrent assertion forms for the odometry block
// ----------------------------------------------------------------------------
`ifndef ACKERMANN_DEAD_RECKONING_ODOMETRY_DEFINES_SVH
`define ACKERMANN_DEAD_RECKONING_ODOMETRY_DEFINES_SVH

// same-cycle implication
`define ADRO_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("odometry assertion failed");

// next-cycle implication
`define ADRO_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("odometry assertion failed");

`endif

[rtl/adro_pkg.sv]
// ----------------------------------------------------------------------------
// adro_pkg
// types, constants and fixed point helpers for the odometry block
// ----------------------------------------------------------------------------
package adro_pkg;

    localparam int TICKS_PER_SECOND_DEF = 100;
    localparam int CORDIC_STEPS_DEF     = 16;
    localparam int ATAN_DEPTH           = 24;
    localparam int DIV_BITS             = 49;

    localparam logic [2:0] CFG_DIST_PER_REV     = 3'd0;
    localparam logic [2:0] CFG_HEADING_GAIN     = 3'd1;
    localparam logic [2:0] CFG_TIME_STEP        = 3'd2;
    localparam logic [2:0] CFG_CORRECTION_LEFT  = 3'd3;
    localparam logic [2:0] CFG_CORRECTION_RIGHT = 3'd4;
    localparam logic [2:0] CFG_LPF_WEIGHT       = 3'd5;

    localparam logic signed [34:0] Q29_PI      = 35'sd1686629713;
    localparam logic signed [34:0] Q29_TWO_PI  = 35'sd3373259426;
    localparam logic signed [34:0] Q29_HALF_PI = 35'sd843314857;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [21:0] Q17_TWO_PI  = 22'sd823550;

    localparam logic signed [31:0] I32MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32MIN = 32'sh8000_0000;

    localparam logic [28:0] ATAN_Q29 [ATAN_DEPTH] = '{
        29'd421657428, 29'd248918915, 29'd131521918, 29'd66762579, 29'd33510843,
        29'd16771758, 29'd8387925, 29'd4194219, 29'd2097141, 29'd1048575,
        29'd524288, 29'd262144, 29'd131072, 29'd65536, 29'd32768, 29'd16384,
        29'd8192, 29'd4096, 29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128, 29'd64
    };

    typedef enum logic [4:0] {
        S_IDLE, S_M_DIST, S_M_RATE, S_M_SPD, S_W_SPD, S_M_F0, S_M_F1, S_W_F,
        S_M_STEER, S_W_STEER, S_RED, S_FOLD1, S_FOLD2, S_ROT, S_CFIN, S_TAN0,
        S_DIV, S_TAN1, S_M_R, S_W_R, S_M_G0, S_M_G1, S_W_G, S_HEAD, S_M_VX,
        S_M_VY, S_M_PX, S_M_PY, S_W_PY, S_DONE
    } adro_state_t;

    // add half an lsb, then floor shift
    function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] v, input int n);
        logic signed [67:0] half;
        half = 68'sd1 <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = I32MAX;
        else if (v < -68'sd2147483648)
            r = I32MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/ackermann_dead_reckoning_odometry.sv]
// ----------------------------------------------------------------------------
// ackermann_dead_reckoning_odometry
// bicycle model wheel odometry on one shared multiplier, cordic and divider
// ----------------------------------------------------------------------------
// tick transaction: two cordic passes and the 49-step divider lie between
// accept and result; large steer angles take extra reduction steps, and the
// divider is skipped when the steer cosine is zero
// reset transaction: goes from accept straight to the done state
// one transaction at a time; the next is taken once the result is registered
// rst_n clears config to defaults and position, heading, counts and filter
`include "ackermann_dead_reckoning_odometry_defines.svh"

module ackermann_dead_reckoning_odometry #(
    parameter int TICKS_PER_SECOND = adro_pkg::TICKS_PER_SECOND_DEF,
    parameter int CORDIC_STEPS     = adro_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [31:0] encoder_revs,
    input  logic signed [15:0] steer_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] x_position,
    output logic signed [31:0] y_position,
    output logic [19:0]        heading,
    output logic signed [18:0] heading_step,
    output logic signed [31:0] speed,
    output logic signed [31:0] speed_filtered,
    output logic signed [31:0] rev_rate
);
    import adro_pkg::*;

    adro_state_t state_reg, state_next;

    logic [23:0] dist_per_rev_reg;
    logic [19:0] heading_gain_reg;
    logic [19:0] time_step_reg;
    logic [15:0] correction_left_reg;
    logic [15:0] correction_right_reg;
    logic [15:0] lpf_weight_reg;

    logic signed [31:0] last_revs_reg, last_dist_reg, filt_reg, px_reg, py_reg;
    logic [19:0]        heading_reg;
    logic               out_valid_reg;

    logic signed [31:0] revs_reg, dist_reg, rate_reg, speed_reg, tan_reg;
    logic signed [15:0] steer_reg;
    logic signed [18:0] step_reg;
    logic signed [67:0] prod_reg, acc_reg;
    logic signed [34:0] ang_reg;
    logic signed [33:0] cx_reg, cy_reg, cos_reg, sin_reg, vx_reg, vy_reg;
    logic               flip_reg, pass_reg, neg_reg;
    logic [4:0]         iter_reg;
    logic [DIV_BITS-1:0] dq_reg;
    logic [32:0]        rem_reg, dvs_reg;
    logic [5:0]         dcnt_reg;
    logic signed [41:0] rr_reg;

    logic signed [31:0] x_position_reg, y_position_reg, speed_out_reg;
    logic signed [31:0] filt_out_reg, rate_out_reg;
    logic [19:0]        heading_out_reg;
    logic signed [18:0] step_out_reg;

    logic               in_take, out_load;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [32:0] revs_diff, dist_diff;
    logic signed [67:0] sum_ap, rnd_r, rnd_g, rnd_x;
    logic signed [33:0] sh_x, sh_y;
    logic signed [33:0] abs_s, abs_c;
    logic [33:0]        div_t;
    logic               div_ge;
    logic signed [21:0] h_raw, h_wrap;
    logic               ang_neg, ang_ge2pi, rot_last, div_last;

    assign cfg_ready = 1'b1;

    assign revs_diff = 33'(revs_reg) - 33'(last_revs_reg);
    assign dist_diff = 33'(dist_reg) - 33'(last_dist_reg);
    assign sum_ap    = acc_reg + prod_reg;
    assign rnd_r     = rnd_shr(prod_reg, 16);
    assign rnd_g     = rnd_shr(sum_ap, 19);
    assign rnd_x     = rnd_shr(prod_reg, 30);
    assign sh_x      = cx_reg >>> iter_reg;
    assign sh_y      = cy_reg >>> iter_reg;
    assign abs_s     = sin_reg[33] ? -sin_reg : sin_reg;
    assign abs_c     = cos_reg[33] ? -cos_reg : cos_reg;
    assign div_t     = {rem_reg, dq_reg[DIV_BITS-1]};
    assign div_ge    = div_t >= {1'b0, dvs_reg};
    assign ang_neg   = ang_reg < 35'sd0;
    assign ang_ge2pi = ang_reg >= Q29_TWO_PI;
    assign rot_last  = iter_reg == 5'(CORDIC_STEPS - 1);
    assign div_last  = dcnt_reg == 6'(DIV_BITS - 1);

    always_comb
    begin
        h_raw  = $signed({2'b00, heading_reg}) + 22'(step_reg);
        h_wrap = h_raw;
        if (h_wrap >= Q17_TWO_PI)
            h_wrap = h_wrap - Q17_TWO_PI;
        if (h_wrap < 22'sd0)
            h_wrap = h_wrap + Q17_TWO_PI;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M_DIST:
            begin
                mul_a = 34'(revs_reg);
                mul_b = 34'(dist_per_rev_reg);
            end
            S_M_RATE:
            begin
                mul_a = 34'(revs_diff);
                mul_b = 34'(TICKS_PER_SECOND);
            end
            S_M_SPD:
            begin
                mul_a = 34'(dist_diff);
                mul_b = 34'(TICKS_PER_SECOND);
            end
            S_M_F0:
            begin
                mul_a = 34'(speed_reg);
                mul_b = 34'(17'h10000 - 17'(lpf_weight_reg));
            end
            S_M_F1:
            begin
                mul_a = 34'(filt_reg);
                mul_b = 34'(lpf_weight_reg);
            end
            S_M_STEER:
            begin
                mul_a = 34'(steer_reg);
                mul_b = (steer_reg > 16'sd0) ? 34'(correction_left_reg)
                                             : 34'(correction_right_reg);
            end
            S_M_R:
            begin
                mul_a = 34'(speed_reg);
                mul_b = 34'(tan_reg);
            end
            S_M_G0:
            begin
                mul_a = 34'($signed(rr_reg[41:21]));
                mul_b = 34'(heading_gain_reg);
            end
            S_M_G1:
            begin
                mul_a = 34'(rr_reg[20:0]);
                mul_b = 34'(heading_gain_reg);
            end
            S_M_VX:
            begin
                mul_a = 34'(speed_reg);
                mul_b = cos_reg;
            end
            S_M_VY:
            begin
                mul_a = 34'(speed_reg);
                mul_b = sin_reg;
            end
            S_M_PX:
            begin
                mul_a = vx_reg;
                mul_b = 34'(time_step_reg);
            end
            S_M_PY:
            begin
                mul_a = vy_reg;
                mul_b = 34'(time_step_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_take)
                    state_next = operation ? S_DONE : S_M_DIST;
            S_M_DIST:  state_next = S_M_RATE;
            S_M_RATE:  state_next = S_M_SPD;
            S_M_SPD:   state_next = S_W_SPD;
            S_W_SPD:   state_next = S_M_F0;
            S_M_F0:    state_next = S_M_F1;
            S_M_F1:    state_next = S_W_F;
            S_W_F:     state_next = S_M_STEER;
            S_M_STEER: state_next = S_W_STEER;
            S_W_STEER: state_next = S_RED;
            S_RED:
                if (!ang_neg && !ang_ge2pi)
                    state_next = S_FOLD1;
            S_FOLD1:   state_next = S_FOLD2;
            S_FOLD2:   state_next = S_ROT;
            S_ROT:
                if (rot_last)
                    state_next = S_CFIN;
            S_CFIN:    state_next = pass_reg ? S_M_VX : S_TAN0;
            S_TAN0:    state_next = (cos_reg == 34'sd0) ? S_M_R : S_DIV;
            S_DIV:
                if (div_last)
                    state_next = S_TAN1;
            S_TAN1:    state_next = S_M_R;
            S_M_R:     state_next = S_W_R;
            S_W_R:     state_next = S_M_G0;
            S_M_G0:    state_next = S_M_G1;
            S_M_G1:    state_next = S_W_G;
            S_W_G:     state_next = S_HEAD;
            S_HEAD:    state_next = S_RED;
            S_M_VX:    state_next = S_M_VY;
            S_M_VY:    state_next = S_M_PX;
            S_M_PX:    state_next = S_M_PY;
            S_M_PY:    state_next = S_W_PY;
            S_W_PY:    state_next = S_DONE;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        in_take  = in_valid && (state_reg == S_IDLE);
        out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    // control, config and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            dist_per_rev_reg     <= '0;
            heading_gain_reg     <= '0;
            time_step_reg        <= 20'd10486;
            correction_left_reg  <= 16'd16384;
            correction_right_reg <= 16'd16384;
            lpf_weight_reg       <= 16'd52429;
            last_revs_reg        <= '0;
            last_dist_reg        <= '0;
            filt_reg             <= '0;
            heading_reg          <= '0;
            px_reg               <= '0;
            py_reg               <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DIST_PER_REV:     dist_per_rev_reg     <= cfg_data;
                    CFG_HEADING_GAIN:     heading_gain_reg     <= cfg_data[19:0];
                    CFG_TIME_STEP:        time_step_reg        <= cfg_data[19:0];
                    CFG_CORRECTION_LEFT:  correction_left_reg  <= cfg_data[15:0];
                    CFG_CORRECTION_RIGHT: correction_right_reg <= cfg_data[15:0];
                    CFG_LPF_WEIGHT:       lpf_weight_reg       <= cfg_data[15:0];
                    default:              ;
                endcase
            end
            if (in_take && operation)
            begin
                last_revs_reg <= '0;
                last_dist_reg <= '0;
                heading_reg   <= '0;
                px_reg        <= '0;
                py_reg        <= '0;
            end
            case (state_reg)
                S_W_SPD:
                begin
                    last_revs_reg <= revs_reg;
                    last_dist_reg <= dist_reg;
                end
                S_W_F:  filt_reg    <= sat32(rnd_shr(sum_ap, 16));
                S_HEAD: heading_reg <= h_wrap[19:0];
                S_M_PY: px_reg      <= sat32(68'(px_reg) + rnd_shr(prod_reg, 20));
                S_W_PY: py_reg      <= sat32(68'(py_reg) + rnd_shr(prod_reg, 20));
                default: ;
            endcase
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (in_take)
        begin
            revs_reg  <= encoder_revs;
            steer_reg <= steer_angle;
            if (operation)
            begin
                speed_reg <= '0;
                rate_reg  <= '0;
                step_reg  <= '0;
            end
        end
        case (state_reg)
            S_M_RATE:  dist_reg  <= sat32(rnd_shr(prod_reg, 12));
            S_M_SPD:   rate_reg  <= sat32(prod_reg);
            S_W_SPD:   speed_reg <= sat32(prod_reg);
            S_M_F1:    acc_reg   <= prod_reg;
            S_W_STEER:
            begin
                ang_reg  <= {prod_reg[33:0], 1'b0};
                pass_reg <= 1'b0;
            end
            S_RED:
            begin
                if (ang_neg)
                    ang_reg <= ang_reg + Q29_TWO_PI;
                else if (ang_ge2pi)
                    ang_reg <= ang_reg - Q29_TWO_PI;
            end
            S_FOLD1:
                if (ang_reg > Q29_PI)
                    ang_reg <= ang_reg - Q29_TWO_PI;
            S_FOLD2:
            begin
                if (ang_reg > Q29_HALF_PI)
                begin
                    ang_reg  <= ang_reg - Q29_PI;
                    flip_reg <= 1'b1;
                end
                else if (ang_reg < -Q29_HALF_PI)
                begin
                    ang_reg  <= ang_reg + Q29_PI;
                    flip_reg <= 1'b1;
                end
                else
                    flip_reg <= 1'b0;
                cx_reg   <= CORDIC_K;
                cy_reg   <= '0;
                iter_reg <= '0;
            end
            S_ROT:
            begin
                if (!ang_neg)
                begin
                    cx_reg  <= cx_reg - sh_y;
                    cy_reg  <= cy_reg + sh_x;
                    ang_reg <= ang_reg - 35'(ATAN_Q29[iter_reg]);
                end
                else
                begin
                    cx_reg  <= cx_reg + sh_y;
                    cy_reg  <= cy_reg - sh_x;
                    ang_reg <= ang_reg + 35'(ATAN_Q29[iter_reg]);
                end
                iter_reg <= iter_reg + 5'd1;
            end
            S_CFIN:
            begin
                cos_reg <= flip_reg ? -cx_reg : cx_reg;
                sin_reg <= flip_reg ? -cy_reg : cy_reg;
            end
            S_TAN0:
            begin
                // vertical steer direction saturates the tangent
                tan_reg  <= sin_reg[33] ? I32MIN : I32MAX;
                neg_reg  <= sin_reg[33] ^ cos_reg[33];
                dq_reg   <= {abs_s[32:0], 16'h0000};
                dvs_reg  <= abs_c[32:0];
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg  <= div_ge ? 33'(div_t - {1'b0, dvs_reg}) : div_t[32:0];
                dq_reg   <= {dq_reg[DIV_BITS-2:0], div_ge};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            S_TAN1:
            begin
                if (neg_reg)
                    tan_reg <= (dq_reg > DIV_BITS'(33'h0_8000_0000)) ? I32MIN
                                                                   : -dq_reg[31:0];
                else
                    tan_reg <= (dq_reg > DIV_BITS'(32'h7FFF_FFFF)) ? I32MAX
                                                                 : dq_reg[31:0];
            end
            S_W_R:
            begin
                if (rnd_r > (68'sd1 <<< 40))
                    rr_reg <= 42'sd1 <<< 40;
                else if (rnd_r < -(68'sd1 <<< 40))
                    rr_reg <= -(42'sd1 <<< 40);
                else
                    rr_reg <= rnd_r[41:0];
            end
            S_M_G1:    acc_reg <= prod_reg <<< 21;
            S_W_G:
            begin
                if (rnd_g > 68'sd262143)
                    step_reg <= 19'sd262143;
                else if (rnd_g < -68'sd262144)
                    step_reg <= -19'sd262144;
                else
                    step_reg <= rnd_g[18:0];
            end
            S_HEAD:
            begin
                ang_reg  <= 35'({h_wrap[19:0], 12'h000});
                pass_reg <= 1'b1;
            end
            S_M_VY:    vx_reg <= rnd_x[33:0];
            S_M_PX:    vy_reg <= rnd_x[33:0];
            default: ;
        endcase
        if (out_load)
        begin
            x_position_reg  <= px_reg;
            y_position_reg  <= py_reg;
            heading_out_reg <= heading_reg;
            step_out_reg    <= step_reg;
            speed_out_reg   <= speed_reg;
            filt_out_reg    <= filt_reg;
            rate_out_reg    <= rate_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign x_position     = x_position_reg;
    assign y_position     = y_position_reg;
    assign heading        = heading_out_reg;
    assign heading_step   = step_out_reg;
    assign speed          = speed_out_reg;
    assign speed_filtered = filt_out_reg;
    assign rev_rate       = rate_out_reg;

    `ADRO_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_reg != S_IDLE)
    `ADRO_ASSERT_SAME(a_heading_wrapped, clk, rst_n, 1'b1, heading_reg < 20'd823550)
    `ADRO_ASSERT_SAME(a_result_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == S_DONE)
    `ADRO_ASSERT_SAME(a_cordic_count, clk, rst_n, state_reg == S_ROT,
        iter_reg < 5'(CORDIC_STEPS))

endmodule
